// ----- hdl/key_event_autorepeat_lock_toggle_unit_macros.svh -----
// Assertion macros for the key event autorepeat unit.
// Included by the top level; expects signals named clock and reset in scope.
`ifndef KEY_EVENT_AUTOREPEAT_LOCK_TOGGLE_UNIT_MACROS_SVH
`define KEY_EVENT_AUTOREPEAT_LOCK_TOGGLE_UNIT_MACROS_SVH
`ifndef SYNTHESIS
// Check cons in the same cycle as ante
`define KEALT_ASSERT_NOW(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("kealt same-cycle check failed");
// Check cons in the cycle after ante
`define KEALT_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("kealt next-cycle check failed");
`else
`define KEALT_ASSERT_NOW(label, ante, cons)
`define KEALT_ASSERT_NEXT(label, ante, cons)
`endif
`endif

// ----- hdl/kealt_pkg.sv -----
// Shared types and constants for the key event autorepeat unit.
// No dependencies; the top level, queue, front and back import this package.
package kealt_pkg;

   // Configuration port
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 16;

   localparam logic [CSR_INDEX_W-1:0] CSR_INITIAL_DELAY = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_REPEAT_PERIOD = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_AUTOREPEAT_ON = 2'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_KEY_OFFSET    = 2'd3;

   localparam logic [15:0] INITIAL_DELAY_RESET = 16'd200;
   localparam logic [15:0] REPEAT_PERIOD_RESET = 16'd50;
   localparam logic [15:0] HELD_MAX            = 16'hffff;

   // Input word kinds
   localparam logic MODE_KEY  = 1'b0;
   localparam logic MODE_TICK = 1'b1;

   // Lock key kinds
   localparam logic [2:0] LOCK_NUM     = 3'd1;
   localparam logic [2:0] LOCK_SCROLL  = 3'd2;
   localparam logic [2:0] LOCK_COMPOSE = 3'd3;
   localparam logic [2:0] LOCK_CAPS    = 3'd4;

   localparam logic [3:0] LED_NUM     = 4'b0001;
   localparam logic [3:0] LED_SCROLL  = 4'b0010;
   localparam logic [3:0] LED_COMP    = 4'b0100;
   localparam logic [3:0] LED_CAPS    = 4'b1000;
   localparam logic [3:0] LED_NONE    = 4'b0000;

   // One queued job: a single key word or a repeat release/press pair
   typedef struct packed {
      logic        pair;
      logic        press;
      logic [7:0]  key;
      logic [31:0] time_ms;
      logic [3:0]  leds;
   } job_type;

   typedef struct packed {
      logic empty;
      logic full;
   } fifo_status_type;

   typedef enum logic {
      BK_FIRST,
      BK_SECOND
   } back_state_type;

endpackage

// ----- hdl/kealt_req_if.sv -----
// Input channel of the key event autorepeat unit: valid/ready plus item fields.
// No dependencies.
interface kealt_req_if;
   logic       valid;
   logic       ready;
   logic       mode;
   logic [7:0] raw_code;
   logic       key_down;
   logic [2:0] lock_kind;
   logic       is_modifier;
   logic       repeat_allowed;

   modport source (output valid, mode, raw_code, key_down, lock_kind, is_modifier,
                   repeat_allowed, input ready);
   modport sink (input valid, mode, raw_code, key_down, lock_kind, is_modifier,
                 repeat_allowed, output ready);
endinterface

// ----- hdl/kealt_rsp_if.sv -----
// Result channel of the key event autorepeat unit: valid/ready plus event fields.
// No dependencies.
interface kealt_rsp_if;
   logic        valid;
   logic        ready;
   logic        event_press;
   logic [7:0]  key_number;
   logic [31:0] time_ms;
   logic [3:0]  led_bits;
   logic        is_repeat;
   logic        last;

   modport source (output valid, event_press, key_number, time_ms, led_bits, is_repeat,
                   last, input ready);
   modport sink (input valid, event_press, key_number, time_ms, led_bits, is_repeat,
                 last, output ready);
endinterface

// ----- hdl/key_event_autorepeat_lock_toggle_unit.sv -----
// Key event filter with typematic autorepeat and lock-key LED toggling.
// Top level; depends on kealt_pkg, kealt_req_if, kealt_rsp_if, kealt_fifo,
// kealt_front, kealt_back and the macros header.
//
// req_ch carries key events (mode 0) and one-millisecond ticks (mode 1) under
// valid/ready. rsp_ch carries the reported events; last marks the final word
// caused by one input. A key event gives at most one word, a tick at most a
// repeat release/press pair. csr_we/csr_index/csr_wdata write the delay,
// period, enable and key offset registers; write them only while idle.
// A word reaches rsp_ch through the queue entry, then the output register.
// Throughput: one input per cycle while the queue has room; a repeat pair
// holds the output register for both of its words, so the sustained rate is
// set by the single result register in the back part.
// A stalled rsp_ch holds its word; the queue (QUEUE_DEPTH jobs) absorbs
// further items until full, then req_ch.ready drops.
// Reset (synchronous, active high) restores register defaults, clears LEDs,
// autorepeat state, the tick counter and the queue; no clearing pass.
`include "key_event_autorepeat_lock_toggle_unit_macros.svh"

module key_event_autorepeat_lock_toggle_unit #(
   parameter int QUEUE_DEPTH = 2
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_we,
   input  logic [kealt_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [kealt_pkg::CSR_DATA_W-1:0]  csr_wdata,
   kealt_req_if.sink                         req_ch,
   kealt_rsp_if.source                       rsp_ch
);
   import kealt_pkg::*;

   logic            q_push;
   logic            q_pop;
   job_type         q_push_job;
   job_type         q_head;
   fifo_status_type q_status;

   // Classify and time
   kealt_front u_front (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .req       (req_ch),
      .q_status  (q_status),
      .push      (q_push),
      .push_job  (q_push_job)
   );

   // Decouple front and back
   kealt_fifo #(
      .DEPTH (QUEUE_DEPTH)
   ) u_fifo (
      .clock    (clock),
      .reset    (reset),
      .push     (q_push),
      .push_job (q_push_job),
      .pop      (q_pop),
      .head     (q_head),
      .status   (q_status)
   );

   // Emit result words
   kealt_back u_back (
      .clock    (clock),
      .reset    (reset),
      .q_status (q_status),
      .head     (q_head),
      .pop      (q_pop),
      .rsp      (rsp_ch)
   );

   // A non-final word is always the release half of a repeat pair
   `KEALT_ASSERT_NOW(a_first_half_release, rsp_ch.valid && !rsp_ch.last, !rsp_ch.event_press && rsp_ch.is_repeat)
   // The press half follows right after the release half is taken
   `KEALT_ASSERT_NEXT(a_pair_press_follows, rsp_ch.valid && rsp_ch.ready && !rsp_ch.last, rsp_ch.valid && rsp_ch.event_press && rsp_ch.is_repeat && rsp_ch.last)
   // The front never pushes into a full queue
   `KEALT_ASSERT_NOW(a_no_push_when_full, q_push, !q_status.full)

endmodule

// ----- hdl/kealt_fifo.sv -----
// Short job queue between the front (classify) and back (emit) parts.
// Depends on kealt_pkg.
module kealt_fifo #(
   parameter int DEPTH = 2
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        push,
   input  kealt_pkg::job_type          push_job,
   input  logic                        pop,
   output kealt_pkg::job_type          head,
   output kealt_pkg::fifo_status_type  status
);
   import kealt_pkg::*;

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

   job_type          mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;

   // Advance pointers and occupancy
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_LAST) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_LAST) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Store pushed jobs
   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_job;
      end
   end

   assign head         = mem_ff[rd_ptr_ff];
   assign status.empty = (count_ff == '0);
   assign status.full  = (count_ff == CNT_FULL);

endmodule

// ----- hdl/kealt_front.sv -----
// Front part: configuration registers, key/tick classification, lock LEDs
// and autorepeat timing; pushes at most one job per input word. Depends on kealt_pkg.
module kealt_front (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  csr_we,
   input  logic [kealt_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [kealt_pkg::CSR_DATA_W-1:0]      csr_wdata,
   kealt_req_if.sink                             req,
   input  kealt_pkg::fifo_status_type            q_status,
   output logic                                  push,
   output kealt_pkg::job_type                    push_job
);
   import kealt_pkg::*;

   // Configuration
   logic [15:0] init_delay_ff, init_delay_in;
   logic [15:0] period_ff, period_in;
   logic        ar_on_ff, ar_on_in;
   logic [7:0]  offset_ff, offset_in;

   // Key state
   logic [3:0]  leds_ff, leds_in;
   logic        active_ff, active_in;
   logic        first_ff, first_in;
   logic [7:0]  rkey_ff, rkey_in;
   logic        en_held_ff, en_held_in;
   logic [15:0] held_ff, held_in;
   logic [31:0] now_ff, now_in;

   logic        accept;
   logic [7:0]  key_val;
   logic [15:0] held_sat;
   logic [15:0] threshold;
   logic [3:0]  lock_bit;
   logic        lit;
   logic        cancel;

   assign req.ready = !q_status.full;
   assign accept    = req.valid && req.ready;

   assign key_val   = {1'b0, req.raw_code[6:0]} + offset_ff;
   assign held_sat  = (held_ff != HELD_MAX) ? held_ff + 16'd1 : held_ff;
   assign threshold = first_ff ? init_delay_ff : period_ff;
   assign lit       = |(leds_ff & lock_bit);
   assign cancel    = active_ff && !req.is_modifier && (req.key_down || key_val == rkey_ff);

   // Decode lock kind into its LED bit
   always_comb begin
      case (req.lock_kind)
         LOCK_NUM:     lock_bit = LED_NUM;
         LOCK_SCROLL:  lock_bit = LED_SCROLL;
         LOCK_COMPOSE: lock_bit = LED_COMP;
         LOCK_CAPS:    lock_bit = LED_CAPS;
         default:      lock_bit = LED_NONE;
      endcase
   end

   // Classify the word, update state, build the job
   always_comb begin
      init_delay_in = init_delay_ff;
      period_in     = period_ff;
      ar_on_in      = ar_on_ff;
      offset_in     = offset_ff;
      leds_in       = leds_ff;
      active_in     = active_ff;
      first_in      = first_ff;
      rkey_in       = rkey_ff;
      en_held_in    = en_held_ff;
      held_in       = held_ff;
      now_in        = now_ff;
      push          = 1'b0;
      push_job.pair  = 1'b0;
      push_job.press = req.key_down;
      push_job.key   = key_val;

      if (csr_we) begin
         case (csr_index)
            CSR_INITIAL_DELAY: init_delay_in = csr_wdata;
            CSR_REPEAT_PERIOD: period_in     = csr_wdata;
            CSR_AUTOREPEAT_ON: ar_on_in      = csr_wdata[0];
            CSR_KEY_OFFSET:    offset_in     = csr_wdata[7:0];
            default: ;
         endcase
      end

      if (accept) begin
         if (req.mode == MODE_TICK) begin
            now_in = now_ff + 32'd1;
            if (!ar_on_ff) begin
               active_in = 1'b0;
            end else if (active_ff) begin
               held_in = held_sat;
               if (held_sat >= threshold) begin
                  if (!en_held_ff) begin
                     active_in = 1'b0;
                  end else begin
                     // fire a repeat pair
                     first_in       = 1'b0;
                     held_in        = '0;
                     push           = 1'b1;
                     push_job.pair  = 1'b1;
                     push_job.press = 1'b1;
                     push_job.key   = rkey_ff;
                  end
               end
            end
         end else begin
            if (cancel) begin
               active_in = 1'b0;
            end
            if (lock_bit != LED_NONE) begin
               // drop lock releases; a press toggles the LED
               if (req.key_down) begin
                  leds_in        = leds_ff ^ lock_bit;
                  push           = 1'b1;
                  push_job.press = !lit;
               end
            end else begin
               if (req.key_down && !req.is_modifier) begin
                  rkey_in    = key_val;
                  first_in   = 1'b1;
                  active_in  = 1'b1;
                  en_held_in = req.repeat_allowed;
                  held_in    = '0;
               end
               push = 1'b1;
            end
         end
      end

      push_job.time_ms = now_in;
      push_job.leds    = leds_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         init_delay_ff <= INITIAL_DELAY_RESET;
         period_ff     <= REPEAT_PERIOD_RESET;
         ar_on_ff      <= 1'b1;
         offset_ff     <= '0;
         leds_ff       <= '0;
         active_ff     <= 1'b0;
         first_ff      <= 1'b0;
         rkey_ff       <= '0;
         en_held_ff    <= 1'b0;
         held_ff       <= '0;
         now_ff        <= '0;
      end else begin
         init_delay_ff <= init_delay_in;
         period_ff     <= period_in;
         ar_on_ff      <= ar_on_in;
         offset_ff     <= offset_in;
         leds_ff       <= leds_in;
         active_ff     <= active_in;
         first_ff      <= first_in;
         rkey_ff       <= rkey_in;
         en_held_ff    <= en_held_in;
         held_ff       <= held_in;
         now_ff        <= now_in;
      end
   end

endmodule

// ----- hdl/kealt_back.sv -----
// Back part: drains the job queue into the registered result channel,
// splitting a repeat job into a release word then a press word. Depends on kealt_pkg.
module kealt_back (
   input  logic                        clock,
   input  logic                        reset,
   input  kealt_pkg::fifo_status_type  q_status,
   input  kealt_pkg::job_type          head,
   output logic                        pop,
   kealt_rsp_if.source                 rsp
);
   import kealt_pkg::*;

   back_state_type state_ff, state_in;
   logic           valid_ff, valid_in;
   logic           press_ff, press_in;
   logic [7:0]     key_ff;
   logic [31:0]    time_ff;
   logic [3:0]     leds_ff;
   logic           rep_ff, rep_in;
   logic           last_ff, last_in;
   logic           load;

   assign load = !valid_ff || rsp.ready;

   // Next state and output word
   always_comb begin
      state_in = state_ff;
      valid_in = valid_ff;
      press_in = press_ff;
      rep_in   = rep_ff;
      last_in  = last_ff;
      pop      = 1'b0;
      if (load) begin
         valid_in = !q_status.empty;
         if (!q_status.empty) begin
            if (head.pair) begin
               rep_in = 1'b1;
               case (state_ff)
                  BK_FIRST: begin
                     press_in = 1'b0;
                     last_in  = 1'b0;
                     state_in = BK_SECOND;
                  end
                  BK_SECOND: begin
                     press_in = 1'b1;
                     last_in  = 1'b1;
                     pop      = 1'b1;
                     state_in = BK_FIRST;
                  end
                  default: begin
                     state_in = BK_FIRST;
                  end
               endcase
            end else begin
               rep_in   = 1'b0;
               press_in = head.press;
               last_in  = 1'b1;
               pop      = 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= BK_FIRST;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         valid_ff <= valid_in;
      end
   end

   // Hold the word while the receiver stalls
   always_ff @(posedge clock) begin
      if (load) begin
         press_ff <= press_in;
         key_ff   <= head.key;
         time_ff  <= head.time_ms;
         leds_ff  <= head.leds;
         rep_ff   <= rep_in;
         last_ff  <= last_in;
      end
   end

   assign rsp.valid       = valid_ff;
   assign rsp.event_press = press_ff;
   assign rsp.key_number  = key_ff;
   assign rsp.time_ms     = time_ff;
   assign rsp.led_bits    = leds_ff;
   assign rsp.is_repeat   = rep_ff;
   assign rsp.last        = last_ff;

endmodule
